// File: sv/kmwc_pkg.sv
// Shared types and constants for the k-mismatch window counter.
// Used by kmwc_cell, kmwc_popcount and k_mismatch_window_counter; no dependencies.
`default_nettype none

package kmwc_pkg;

	localparam int unsigned PATTERN_WORDS = 4;
	localparam int unsigned PATTERN_BYTES = 32;
	localparam int unsigned PIDX_W        = 5;
	localparam int unsigned WORD_W        = 64;
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned LEN_REG_W     = 6;
	localparam int unsigned GROUP_SIZE    = 8;
	localparam int unsigned GROUP_CNT_W   = 4;
	localparam logic [LEN_REG_W-1:0] LENGTH_RESET = 6'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN0 = 3'd0,
		REG_PATTERN1 = 3'd1,
		REG_PATTERN2 = 3'd2,
		REG_PATTERN3 = 3'd3,
		REG_LENGTH   = 3'd4,
		REG_LIMIT    = 3'd5
	} cfg_reg_t;

	typedef logic [PATTERN_WORDS-1:0][WORD_W-1:0] pattern_words_t;
	typedef logic [PATTERN_BYTES-1:0][7:0] pattern_bytes_t;

	// Control that travels with a beat down the pipeline.
	typedef struct packed {
		logic valid;
		logic last;
		logic full;
	} stage_ctl_t;

endpackage

`default_nettype wire

// File: sv/kmwc_cell.sv
// One cell of the window row: holds one text byte, its aligned pattern byte and
// the registered mismatch flag. Depends on kmwc_pkg.
`default_nettype none

module kmwc_cell #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned LEN_W = 6
) (
	input  logic                    clk,
	input  logic                    shift_en,
	input  logic                    adv_en,
	input  logic [7:0]              byte_in,
	input  kmwc_pkg::pattern_bytes_t pattern,
	input  logic [LEN_W-1:0]        eff_len,
	output logic [7:0]              byte_out,
	output logic                    mismatch_s2
);

	logic [7:0]       byte_q;
	logic [7:0]       apat_q;
	logic             use_q;
	logic             in_use;
	logic [LEN_W-1:0] rel;
	logic [31:0]      rel_w;
	logic [7:0]       apat_d;

	// Window position INDEX (0 is newest) lines up with pattern byte len-1-INDEX.
	always_comb begin
		in_use = int'(eff_len) > int'(INDEX);
		rel    = eff_len - LEN_W'(INDEX + 1);
		rel_w  = 32'(rel);
		if (in_use && (rel_w < 32'(kmwc_pkg::PATTERN_BYTES))) begin
			apat_d = pattern[rel_w[kmwc_pkg::PIDX_W-1:0]];
		end else begin
			apat_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
		apat_q <= apat_d;
		use_q  <= in_use;
		if (adv_en) begin
			mismatch_s2 <= use_q && (byte_q != apat_q);
		end
	end

	assign byte_out = byte_q;

endmodule

`default_nettype wire

// File: sv/kmwc_popcount.sv
// Two-stage registered population count of the mismatch flags from the cell row.
// Depends on kmwc_pkg for the group size and the stage control struct.
`default_nettype none

module kmwc_popcount #(
	parameter int unsigned WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [WIDTH-1:0]             bits,
	input  kmwc_pkg::stage_ctl_t         ctl_in,
	output kmwc_pkg::stage_ctl_t         ctl_s4,
	output logic [$clog2(WIDTH+1)-1:0]   sum_s4
);

	localparam int unsigned NG    = (WIDTH + kmwc_pkg::GROUP_SIZE - 1) / kmwc_pkg::GROUP_SIZE;
	localparam int unsigned PAD_W = NG * kmwc_pkg::GROUP_SIZE;
	localparam int unsigned SUM_W = $clog2(WIDTH + 1);

	logic [PAD_W-1:0]                        padded;
	logic [NG-1:0][kmwc_pkg::GROUP_CNT_W-1:0] grp_d;
	logic [NG-1:0][kmwc_pkg::GROUP_CNT_W-1:0] grp_s3;
	kmwc_pkg::stage_ctl_t                    ctl_s3;
	logic [SUM_W-1:0]                        sum_d;

	assign padded = PAD_W'(bits);

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < kmwc_pkg::GROUP_SIZE; k++) begin
				grp_d[g] = grp_d[g]
					+ kmwc_pkg::GROUP_CNT_W'(padded[g * kmwc_pkg::GROUP_SIZE + k]);
			end
		end
	end

	always_comb begin
		sum_d = '0;
		for (int g = 0; g < NG; g++) begin
			sum_d = sum_d + SUM_W'(grp_s3[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_in;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_s3 <= grp_d;
			sum_s4 <= sum_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/k_mismatch_window_counter.sv
// Top level of the k-mismatch window counter: configuration registers, cell row,
// popcount pipeline and output stage. Depends on kmwc_pkg, kmwc_cell, kmwc_popcount.
//
// Usage: text bytes enter on the input channel (in_valid, in_stall, text_byte,
// last_byte), one beat per byte. Every input beat yields exactly one output beat
// (out_valid, out_stall, window_hit, match_count, text_done). Once the last
// pattern_length bytes of the current text are present, window_hit reports
// whether at most mismatch_limit of them differ from the pattern, and
// match_count carries the saturating hit count of the text so far. A beat with
// last_byte set ends the text; its result has text_done set and the final count.
// A byte passes stages s1 to s4 and the output register. Throughput is one byte
// per cycle while en is high: the row shifts on each accepted byte, stages advance.
// The pipeline has one common advance; when a result waits under out_stall the
// whole pipeline holds and in_stall is raised in the same cycle.
// Reset clears the pipeline, the fill count and the hit count, and loads the
// default configuration (zero pattern, length 16, limit 0). Configuration is
// written through cfg_we/cfg_index/cfg_data and applies to the next byte.
`default_nettype none

module k_mismatch_window_counter #(
	parameter int unsigned MAX_PATTERN = 32,
	parameter int unsigned COUNT_BITS  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [kmwc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kmwc_pkg::WORD_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        text_byte,
	input  logic                              last_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              window_hit,
	output logic [31:0]                       match_count,
	output logic                              text_done
);

	localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int unsigned SUM_W = $clog2(MAX_PATTERN + 1);

	kmwc_pkg::pattern_words_t            pattern_q;
	kmwc_pkg::pattern_bytes_t            pattern_bytes;
	logic [kmwc_pkg::LEN_REG_W-1:0]      length_q;
	logic [kmwc_pkg::LEN_REG_W-1:0]      limit_q;

	logic                                en;
	logic                                accept;
	logic [LEN_W-1:0]                    eff_len;
	logic [LEN_W-1:0]                    fill_q;
	logic [LEN_W-1:0]                    fill_inc;

	kmwc_pkg::stage_ctl_t                ctl_s1;
	kmwc_pkg::stage_ctl_t                ctl_s2;
	kmwc_pkg::stage_ctl_t                ctl_s4;
	logic [SUM_W-1:0]                    sum_s4;

	logic [MAX_PATTERN-1:0][7:0]         win;
	logic [MAX_PATTERN-1:0]              mism_s2;

	logic [COUNT_BITS-1:0]               total_q;
	logic [COUNT_BITS-1:0]               total_next;
	logic                                hit;

	logic                                out_valid_q;
	logic                                window_hit_q;
	logic [31:0]                         match_count_q;
	logic                                text_done_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= kmwc_pkg::LENGTH_RESET;
			limit_q   <= '0;
		end else if (cfg_we) begin
			unique case (kmwc_pkg::cfg_reg_t'(cfg_index))
				kmwc_pkg::REG_PATTERN0: pattern_q[0] <= cfg_data;
				kmwc_pkg::REG_PATTERN1: pattern_q[1] <= cfg_data;
				kmwc_pkg::REG_PATTERN2: pattern_q[2] <= cfg_data;
				kmwc_pkg::REG_PATTERN3: pattern_q[3] <= cfg_data;
				kmwc_pkg::REG_LENGTH:   length_q <= cfg_data[kmwc_pkg::LEN_REG_W-1:0];
				kmwc_pkg::REG_LIMIT:    limit_q  <= cfg_data[kmwc_pkg::LEN_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign pattern_bytes = pattern_q;

	// A length of zero acts as one; a length beyond the row acts as the row size.
	always_comb begin
		if (length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (int'(length_q) > int'(MAX_PATTERN)) begin
			eff_len = LEN_W'(MAX_PATTERN);
		end else begin
			eff_len = LEN_W'(length_q);
		end
	end

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;
	assign accept   = in_valid && en;

	assign fill_inc = (int'(fill_q) < int'(MAX_PATTERN)) ? fill_q + 1'b1 : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			if (accept) begin
				fill_q <= last_byte ? '0 : fill_inc;
			end
			if (en) begin
				ctl_s1.valid <= in_valid;
				ctl_s1.last  <= last_byte;
				ctl_s1.full  <= fill_inc >= eff_len;
				ctl_s2       <= ctl_s1;
			end
		end
	end

	// The byte row: cell 0 takes the new byte, each cell hands its byte onward.
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic [7:0] shift_in;
		if (j == 0) begin : g_head
			assign shift_in = text_byte;
		end else begin : g_body
			assign shift_in = win[j-1];
		end
		kmwc_cell #(
			.INDEX (j),
			.LEN_W (LEN_W)
		) u_cell (
			.clk         (clk),
			.shift_en    (accept),
			.adv_en      (en),
			.byte_in     (shift_in),
			.pattern     (pattern_bytes),
			.eff_len     (eff_len),
			.byte_out    (win[j]),
			.mismatch_s2 (mism_s2[j])
		);
	end

	kmwc_popcount #(
		.WIDTH (MAX_PATTERN)
	) u_popcount (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.bits   (mism_s2),
		.ctl_in (ctl_s2),
		.ctl_s4 (ctl_s4),
		.sum_s4 (sum_s4)
	);

	always_comb begin
		hit = ctl_s4.full && (int'(sum_s4) <= int'(limit_q));
		if (hit && (total_q != '1)) begin
			total_next = total_q + 1'b1;
		end else begin
			total_next = total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else if (en) begin
			out_valid_q <= ctl_s4.valid;
			if (ctl_s4.valid) begin
				total_q <= ctl_s4.last ? '0 : total_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl_s4.valid) begin
			window_hit_q  <= hit;
			match_count_q <= 32'(total_next);
			text_done_q   <= ctl_s4.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign window_hit  = window_hit_q;
	assign match_count = match_count_q;
	assign text_done   = text_done_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= int'(MAX_PATTERN))
		else $error("window fill beyond the row size");

	a_fill_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> fill_q == '0)
		else $error("window fill not cleared after the last byte");

	a_total_clear: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl_s4.valid && ctl_s4.last |=> total_q == '0)
		else $error("hit count not cleared after the end of the text");

	a_hit_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl_s4.valid && !ctl_s4.full |=> !window_hit_q)
		else $error("hit reported before the window filled");

endmodule

`default_nettype wire

// File: sim/k_mismatch_window_counter_tb.sv
// Self-checking testbench for k_mismatch_window_counter: text beats go through a bursty
// driver, results come back under a patterned stall and are checked against a predictor.
// Depends on kmwc_pkg and the k_mismatch_window_counter RTL.
module k_mismatch_window_counter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PIPE_LATENCY = 4;
	localparam int unsigned PHASE_BEATS  = 140;
	localparam int unsigned PHASE_COUNT  = 10;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam logic [kmwc_pkg::CFG_IDX_W-1:0] UNUSED_INDEX_LO = 3'd6;
	localparam logic [kmwc_pkg::CFG_IDX_W-1:0] UNUSED_INDEX_HI = 3'd7;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} text_beat_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] count;
		logic        done;
	} window_result_t;

	logic                           clk;
	logic                           arst_n      = 1'b0;
	logic                           cfg_we      = 1'b0;
	logic [kmwc_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
	logic [kmwc_pkg::WORD_W-1:0]    cfg_data    = '0;
	logic                           in_valid    = 1'b0;
	logic                           in_stall;
	logic [7:0]                     text_byte   = 8'h00;
	logic                           last_byte   = 1'b0;
	logic                           out_valid;
	logic                           out_stall   = 1'b0;
	logic                           window_hit;
	logic [31:0]                    match_count;
	logic                           text_done;

	k_mismatch_window_counter DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.window_hit  (window_hit),
		.match_count (match_count),
		.text_done   (text_done)
	);

	// Predictor copy of the configuration and of the window state.
	logic [kmwc_pkg::WORD_W-1:0] pat_words [kmwc_pkg::PATTERN_WORDS] = '{default: '0};
	logic [5:0]        pat_len   = kmwc_pkg::LENGTH_RESET;
	logic [5:0]        mis_limit = '0;
	logic [7:0]        text_hist [kmwc_pkg::PATTERN_BYTES] = '{default: 8'h00};
	int unsigned       fill_level = 0;
	logic [31:0]       hit_total  = '0;

	text_beat_t     pending_beats [$];
	window_result_t expected_results [$];
	int unsigned    error_count = 0;
	int unsigned    burst_left  = 0;
	int unsigned    gap_left    = 0;
	int unsigned    stall_seg   = 0;
	int unsigned    stall_mode  = 0;
	int unsigned    stall_run   = 0;
	window_result_t want;
	window_result_t seen;

	function automatic int unsigned active_length();
		if (pat_len == 0)
			return 1;
		if (pat_len > kmwc_pkg::PATTERN_BYTES)
			return kmwc_pkg::PATTERN_BYTES;
		return pat_len;
	endfunction

	function automatic logic [7:0] pattern_byte(input int unsigned idx);
		return pat_words[idx / 8][(idx % 8) * 8 +: 8];
	endfunction

	function automatic window_result_t predict_window(input logic [7:0] value, input logic last);
		window_result_t res;
		int unsigned len;
		int unsigned diff;
		len = active_length();
		for (int i = kmwc_pkg::PATTERN_BYTES - 1; i > 0; i--)
			text_hist[i] = text_hist[i - 1];
		text_hist[0] = value;
		if (fill_level < kmwc_pkg::PATTERN_BYTES)
			fill_level++;
		res.hit = 1'b0;
		if (fill_level >= len) begin
			diff = 0;
			// Oldest window byte lines up with pattern byte 0.
			for (int i = 0; i < len; i++)
				if (text_hist[len - 1 - i] != pattern_byte(i))
					diff++;
			if (diff <= mis_limit) begin
				res.hit = 1'b1;
				if (hit_total != '1)
					hit_total++;
			end
		end
		res.count = hit_total;
		res.done = last;
		if (last) begin
			fill_level = 0;
			hit_total = '0;
		end
		return res;
	endfunction

	task automatic note_mismatch(input string what, input window_result_t exp_r,
			input window_result_t act_r);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s: expected hit=%0b count=%0d done=%0b, %s",
				$realtime, what, exp_r.hit, exp_r.count, exp_r.done,
				$sformatf("got hit=%0b count=%0d done=%0b",
					act_r.hit, act_r.count, act_r.done));
	endtask

	task automatic cfg_write(input logic [kmwc_pkg::CFG_IDX_W-1:0] idx,
			input logic [kmwc_pkg::WORD_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			kmwc_pkg::REG_PATTERN0: pat_words[0] = data;
			kmwc_pkg::REG_PATTERN1: pat_words[1] = data;
			kmwc_pkg::REG_PATTERN2: pat_words[2] = data;
			kmwc_pkg::REG_PATTERN3: pat_words[3] = data;
			kmwc_pkg::REG_LENGTH:   pat_len = data[5:0];
			kmwc_pkg::REG_LIMIT:    mis_limit = data[5:0];
			default: ;
		endcase
	endtask

	task automatic cfg_idle();
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_beat(input logic [7:0] value, input logic last);
		pending_beats.push_back('{value, last});
	endtask

	task automatic wait_drained();
		while (pending_beats.size() != 0 || expected_results.size() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	// The first phases pin the extremes; the rest draw a setting at random.
	task automatic program_setting(input int unsigned phase);
		logic [5:0]                  len_val;
		logic [5:0]                  lim_val;
		logic [kmwc_pkg::WORD_W-1:0] w;
		case (phase)
			0: begin len_val = 6'd1;  lim_val = 6'd0;  end
			1: begin len_val = 6'd32; lim_val = 6'd32; end
			2: begin len_val = 6'd32; lim_val = 6'd0;  end
			3: begin len_val = 6'd0;  lim_val = 6'd0;  end
			4: begin len_val = 6'($urandom_range(33, 63)); lim_val = 6'd63; end
			default: begin
				len_val = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(2, 20));
				lim_val = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(0, 3));
			end
		endcase
		for (int i = 0; i < kmwc_pkg::PATTERN_WORDS; i++) begin
			case ($urandom_range(0, 7))
				0: w = '0;
				1: w = '1;
				default: w = {$urandom, $urandom};
			endcase
			cfg_write(kmwc_pkg::cfg_reg_t'(kmwc_pkg::REG_PATTERN0 + i), w);
		end
		w = {$urandom, $urandom};
		if ($urandom_range(0, 1) == 0)
			w[kmwc_pkg::WORD_W-1:6] = '0;
		w[5:0] = len_val;
		cfg_write(kmwc_pkg::REG_LENGTH, w);
		w = {$urandom, $urandom};
		if ($urandom_range(0, 1) == 0)
			w[kmwc_pkg::WORD_W-1:6] = '0;
		w[5:0] = lim_val;
		cfg_write(kmwc_pkg::REG_LIMIT, w);
		if ($urandom_range(0, 2) == 0)
			cfg_write($urandom_range(0, 1) ? UNUSED_INDEX_LO : UNUSED_INDEX_HI,
				{$urandom, $urandom});
		cfg_idle();
	endtask

	// Mostly pattern copies with a few corrupted bytes, mixed with short runs of noise.
	// A phase may stop in the middle of a text, so the next setting applies mid-text.
	task automatic queue_traffic(input int unsigned beats);
		text_beat_t  seg [$];
		int unsigned len;
		int unsigned nmut;
		int unsigned made;
		made = 0;
		while (made < beats) begin
			seg.delete();
			len = active_length();
			if ($urandom_range(0, 9) < 6) begin
				for (int i = 0; i < len; i++)
					seg.push_back('{pattern_byte(i), 1'b0});
				nmut = $urandom_range(0, (mis_limit + 2 < len) ? mis_limit + 2 : len);
				repeat (nmut)
					seg[$urandom_range(0, len - 1)].value = 8'($urandom_range(0, 255));
			end else begin
				repeat ($urandom_range(1, 8))
					seg.push_back('{8'($urandom_range(0, 255)), 1'b0});
			end
			if ($urandom_range(0, 4) == 0)
				seg[seg.size() - 1].last = 1'b1;
			made += seg.size();
			pending_beats = {pending_beats, seg};
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Driver: bursts of beats with random gaps; a stalled beat is held unchanged.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				expected_results.push_back(predict_window(pending_beats[0].value,
					pending_beats[0].last));
				pending_beats.pop_front();
			end
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_beats.size() != 0) begin
				in_valid <= 1'b1;
				text_byte <= pending_beats[0].value;
				last_byte <= pending_beats[0].last;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: segments of no stall, random stall, stall runs, or alternation.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_seg == 0) begin
				stall_seg = $urandom_range(20, 200);
				stall_mode = $urandom_range(0, 3);
			end
			stall_seg--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: begin
					if (stall_run == 0)
						stall_run = $urandom_range(1, 16);
					stall_run--;
					out_stall <= (stall_run >= 8);
				end
				default: out_stall <= ~out_stall;
			endcase
		end
	end

	// Monitor: every accepted result beat is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen = '{window_hit, match_count, text_done};
			if (expected_results.size() == 0) begin
				note_mismatch("result beat with nothing expected", '0, seen);
			end else begin
				want = expected_results.pop_front();
				if (seen !== want)
					note_mismatch("result mismatch", want, seen);
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset setting: zero pattern of length 16, no mismatch allowed.
		repeat (16) queue_beat(8'h00, 1'b0);
		queue_beat(8'hFF, 1'b1);
		wait_drained();

		// Writes to unused indexes are dropped; a length of zero behaves as one.
		cfg_write(UNUSED_INDEX_LO, '1);
		cfg_write(UNUSED_INDEX_HI, '1);
		cfg_write(kmwc_pkg::REG_LENGTH, '0);
		cfg_write(kmwc_pkg::REG_PATTERN0, 64'h0000_0000_0000_00A5);
		cfg_idle();
		queue_beat(8'hA5, 1'b0);
		queue_beat(8'h5A, 1'b0);
		queue_beat(8'hA5, 1'b1);
		wait_drained();

		// Upper data bits are ignored by the length register; a limit above the
		// length makes every full window a hit.
		cfg_write(kmwc_pkg::REG_LENGTH, 64'hFFFF_FFFF_FFFF_FFC1);
		cfg_write(kmwc_pkg::REG_LIMIT, 64'd32);
		cfg_idle();
		queue_beat(8'h00, 1'b0);
		queue_beat(8'hFF, 1'b1);
		wait_drained();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			program_setting(p);
			queue_traffic(PHASE_BEATS);
			wait_drained();
		end

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
